// File: rtl/pdll_pkg.sv
// shared types and constants of the pooled doubly linked list manager
package pdll_pkg;

    localparam int OP_W     = 4;
    localparam int HANDLE_W = 4;
    localparam int ITEM_W   = 32;
    localparam int COUNT_W  = 8;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE     = 4'd0,
        OP_COUNT      = 4'd1,
        OP_FIRST      = 4'd2,
        OP_LAST       = 4'd3,
        OP_NEXT       = 4'd4,
        OP_PREV       = 4'd5,
        OP_CURR       = 4'd6,
        OP_INS_AFTER  = 4'd7,
        OP_INS_BEFORE = 4'd8,
        OP_APPEND     = 4'd9,
        OP_PREPEND    = 4'd10,
        OP_REMOVE     = 4'd11,
        OP_TRIM       = 4'd12,
        OP_CONCAT     = 4'd13,
        OP_FREE       = 4'd14
    } t_op;

    // cursor position within a list
    typedef enum logic [1:0] {
        MODE_BEFORE = 2'd0,
        MODE_IN     = 2'd1,
        MODE_AFTER  = 2'd2
    } t_mode;

    // controller states, also used as the datapath command
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HREAD,
        ST_DECODE,
        ST_EXEC,
        ST_LRD,
        ST_LCAP,
        ST_MOVE,
        ST_ITEM_RD,
        ST_RM1,
        ST_TR1,
        ST_GIVE,
        ST_W1,
        ST_W2,
        ST_H2RD,
        ST_H2CAP,
        ST_CC1,
        ST_CC2,
        ST_FR1,
        ST_FIN,
        ST_NULL,
        ST_CR_RD,
        ST_CR_WR
    } t_state;

    // request payload
    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [HANDLE_W-1:0] list_sel;
        logic [HANDLE_W-1:0] second_list;
        logic [ITEM_W-1:0]   item_in;
    } t_req;

    // result payload
    typedef struct packed {
        logic                status;
        logic                item_present;
        logic [ITEM_W-1:0]   item_out;
        logic [HANDLE_W-1:0] new_handle;
        logic [COUNT_W-1:0]  element_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic   accept;
        t_state step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic h_ok;
        logic h2_ok;
        logic cur_in;
        logic tl_ok;
        logic alloc_ok;
    } t_stat;

endpackage

// File: rtl/pdll_ram.sv
// generic single write port memory with registered read
module pdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pdll_ctrl.sv
// sequencing state machine of the list manager
module pdll_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pdll_pkg::t_op    i_op,
    input  pdll_pkg::t_stat  i_stat,
    output pdll_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    pdll_pkg::t_state r_state;
    pdll_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdll_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.step   = r_state;
        case (r_state)
            pdll_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_op == pdll_pkg::OP_CREATE) ? pdll_pkg::ST_CR_RD
                                                           : pdll_pkg::ST_HREAD;
                end
            end
            pdll_pkg::ST_HREAD: begin
                n_state = i_stat.h_ok ? pdll_pkg::ST_DECODE : pdll_pkg::ST_NULL;
            end
            pdll_pkg::ST_DECODE: n_state = pdll_pkg::ST_EXEC;
            pdll_pkg::ST_EXEC: begin
                case (i_stat.op)
                    pdll_pkg::OP_COUNT:  n_state = pdll_pkg::ST_FIN;
                    pdll_pkg::OP_FIRST,
                    pdll_pkg::OP_LAST,
                    pdll_pkg::OP_CURR:   n_state = pdll_pkg::ST_ITEM_RD;
                    pdll_pkg::OP_CONCAT: n_state = pdll_pkg::ST_H2RD;
                    pdll_pkg::OP_FREE:   n_state = pdll_pkg::ST_FR1;
                    default:             n_state = pdll_pkg::ST_LRD;
                endcase
            end
            pdll_pkg::ST_LRD: n_state = pdll_pkg::ST_LCAP;
            pdll_pkg::ST_LCAP: begin
                case (i_stat.op)
                    pdll_pkg::OP_NEXT,
                    pdll_pkg::OP_PREV:   n_state = pdll_pkg::ST_MOVE;
                    pdll_pkg::OP_REMOVE: begin
                        n_state = i_stat.cur_in ? pdll_pkg::ST_RM1 : pdll_pkg::ST_FIN;
                    end
                    pdll_pkg::OP_TRIM: begin
                        n_state = i_stat.tl_ok ? pdll_pkg::ST_TR1 : pdll_pkg::ST_FIN;
                    end
                    default: begin
                        n_state = i_stat.alloc_ok ? pdll_pkg::ST_W1 : pdll_pkg::ST_FIN;
                    end
                endcase
            end
            pdll_pkg::ST_MOVE:    n_state = pdll_pkg::ST_ITEM_RD;
            pdll_pkg::ST_ITEM_RD: n_state = pdll_pkg::ST_FIN;
            pdll_pkg::ST_RM1:     n_state = pdll_pkg::ST_GIVE;
            pdll_pkg::ST_TR1:     n_state = pdll_pkg::ST_GIVE;
            pdll_pkg::ST_GIVE:    n_state = pdll_pkg::ST_FIN;
            pdll_pkg::ST_W1:      n_state = pdll_pkg::ST_W2;
            pdll_pkg::ST_W2:      n_state = pdll_pkg::ST_FIN;
            pdll_pkg::ST_H2RD: begin
                n_state = i_stat.h2_ok ? pdll_pkg::ST_H2CAP : pdll_pkg::ST_NULL;
            end
            pdll_pkg::ST_H2CAP:   n_state = pdll_pkg::ST_CC1;
            pdll_pkg::ST_CC1:     n_state = pdll_pkg::ST_CC2;
            pdll_pkg::ST_CC2:     n_state = pdll_pkg::ST_FIN;
            pdll_pkg::ST_FR1:     n_state = pdll_pkg::ST_FIN;
            pdll_pkg::ST_FIN:     n_state = pdll_pkg::ST_IDLE;
            pdll_pkg::ST_NULL:    n_state = pdll_pkg::ST_IDLE;
            pdll_pkg::ST_CR_RD:   n_state = pdll_pkg::ST_CR_WR;
            pdll_pkg::ST_CR_WR:   n_state = pdll_pkg::ST_IDLE;
            default:              n_state = pdll_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != pdll_pkg::ST_IDLE);

    // a transfer always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state != pdll_pkg::ST_IDLE))
        else $error("accepted request did not start work");

    // every result-producing state returns to idle
    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdll_pkg::ST_FIN || r_state == pdll_pkg::ST_NULL ||
         r_state == pdll_pkg::ST_CR_WR) |=> (r_state == pdll_pkg::ST_IDLE))
        else $error("controller did not return to idle after result");

    // work only begins right after a transfer
    a_start_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdll_pkg::ST_HREAD || r_state == pdll_pkg::ST_CR_RD) |->
        $past(o_cmd.accept))
        else $error("work started without a transfer");

endmodule

// File: rtl/pdll_dp.sv
// head and node memories, free pools and working registers of the list manager
module pdll_dp #(
    parameter int NUM_HEADS = 16,
    parameter int NUM_NODES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pdll_pkg::t_cmd   i_cmd,
    input  pdll_pkg::t_req   i_req,
    output pdll_pkg::t_stat  o_stat,
    output pdll_pkg::t_rsp   o_rsp,
    output logic             o_valid
);

    localparam int NW  = $clog2(NUM_NODES + 1);
    localparam int NAW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int HW  = $clog2(NUM_HEADS + 1);
    localparam int HAW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
    localparam int HDW = 4 * NW + 2;
    localparam int IW  = pdll_pkg::ITEM_W;
    localparam logic [NW-1:0] NIL  = NW'(NUM_NODES);
    localparam logic [HW-1:0] NILH = HW'(NUM_HEADS);
    localparam logic [HDW-1:0] HEAD_RST = {NIL, NIL, NIL, pdll_pkg::MODE_BEFORE, {NW{1'b0}}};

    // request
    pdll_pkg::t_op                 r_op;
    logic [pdll_pkg::HANDLE_W-1:0] r_h;
    logic [pdll_pkg::HANDLE_W-1:0] r_h2;
    logic [IW-1:0]                 r_item;

    // working copy of the selected head and the second head
    logic [NW-1:0]   r_hd, r_tl, r_cur, r_cnt;
    pdll_pkg::t_mode r_mode;
    logic [NW-1:0]   r_hd2, r_tl2, r_cnt2;

    // node scratch
    logic [NW-1:0] r_c, r_p, r_nx;
    logic [IW-1:0] r_it;
    logic          r_pres;

    // free pools: recycled stacks in front of a fresh counter
    logic [NW-1:0]        r_fnt, r_fnext, r_nfresh, r_anode;
    logic                 r_aok;
    logic [HW-1:0]        r_fht, r_hfresh;
    logic [NUM_HEADS-1:0] r_used;

    pdll_pkg::t_rsp r_rsp;
    logic           r_valid;

    // memory ports
    logic           head_we;
    logic [HAW-1:0] head_waddr, head_raddr;
    logic [HDW-1:0] head_wdata, head_rdata;
    logic           link_we;
    logic [HAW-1:0] link_waddr;
    logic [HW-1:0]  link_wdata, link_rdata;
    logic           next_we, prev_we, item_we;
    logic [NAW-1:0] next_waddr, next_raddr, prev_waddr, prev_raddr;
    logic [NAW-1:0] item_waddr, item_raddr;
    logic [NW-1:0]  next_wdata, next_rdata, prev_wdata, prev_rdata;
    logic [IW-1:0]  item_rdata;

    // head read fields
    logic [NW-1:0] hr_hd, hr_tl, hr_cur, hr_cnt;
    logic [1:0]    hr_mode;

    // derived flags
    logic          hdv, tlv, curv, pv, nxv, hd2v, cur_in;
    logic          link_b, link_f, is_ins, k_back, k_front, k_after;
    logic          cursor_op, fin_pres;
    logic          cr_stack, cr_ok;
    logic [HW-1:0] cr_h;

    assign {hr_hd, hr_tl, hr_cur, hr_mode, hr_cnt} = head_rdata;

    assign hdv    = (r_hd != NIL);
    assign tlv    = (r_tl != NIL);
    assign curv   = (r_cur != NIL);
    assign pv     = (r_p != NIL);
    assign nxv    = (r_nx != NIL);
    assign hd2v   = (r_hd2 != NIL);
    assign cur_in = (r_mode == pdll_pkg::MODE_IN) && curv;

    // insert placement
    assign link_b  = tlv && (r_cnt != '0);
    assign link_f  = hdv && (r_cnt != '0);
    assign is_ins  = (r_op == pdll_pkg::OP_INS_AFTER) || (r_op == pdll_pkg::OP_INS_BEFORE);
    assign k_back  = (r_op == pdll_pkg::OP_APPEND) ||
                     (is_ins && (r_mode == pdll_pkg::MODE_AFTER));
    assign k_front = !k_back && ((r_op == pdll_pkg::OP_PREPEND) || (is_ins && !cur_in));
    assign k_after = (r_op == pdll_pkg::OP_INS_AFTER);

    assign cursor_op = (r_op inside {[pdll_pkg::OP_FIRST:pdll_pkg::OP_CURR]});
    assign fin_pres  = cursor_op ? cur_in : r_pres;

    // head allocation
    assign cr_stack = (r_fht != NILH);
    assign cr_ok    = cr_stack || (r_hfresh < NILH);
    assign cr_h     = cr_stack ? r_fht : r_hfresh;

    // status to the controller
    assign o_stat.op       = r_op;
    assign o_stat.h_ok     = (r_h < NUM_HEADS) && r_used[HAW'(r_h)] &&
                             (r_op inside {[pdll_pkg::OP_COUNT:pdll_pkg::OP_FREE]});
    assign o_stat.h2_ok    = (r_h2 != r_h) && (r_h2 < NUM_HEADS) && r_used[HAW'(r_h2)];
    assign o_stat.cur_in   = cur_in;
    assign o_stat.tl_ok    = (r_cnt != '0) && tlv;
    assign o_stat.alloc_ok = r_aok;

    // head memory and free head links
    always_comb begin
        head_we    = 1'b0;
        head_waddr = HAW'(r_h);
        head_wdata = {r_hd, r_tl, r_cur, r_mode, r_cnt};
        head_raddr = (i_cmd.step == pdll_pkg::ST_H2RD) ? HAW'(r_h2) : HAW'(r_h);
        link_we    = 1'b0;
        link_waddr = HAW'(r_h);
        link_wdata = r_fht;
        case (i_cmd.step)
            pdll_pkg::ST_CR_WR: begin
                head_we    = cr_ok;
                head_waddr = HAW'(cr_h);
                head_wdata = HEAD_RST;
            end
            pdll_pkg::ST_CC2: begin
                head_we    = 1'b1;
                head_waddr = HAW'(r_h2);
                head_wdata = HEAD_RST;
                link_we    = 1'b1;
                link_waddr = HAW'(r_h2);
            end
            pdll_pkg::ST_FR1: link_we = 1'b1;
            pdll_pkg::ST_FIN: head_we = 1'b1;
            default: ;
        endcase
    end

    // node memories
    always_comb begin
        next_we    = 1'b0;
        next_waddr = NAW'(r_c);
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_waddr = NAW'(r_c);
        prev_wdata = NIL;
        item_we    = 1'b0;
        item_waddr = NAW'(r_anode);
        next_raddr = (i_cmd.step == pdll_pkg::ST_LRD) ? NAW'(r_c) : NAW'(r_fnt);
        prev_raddr = NAW'(r_c);
        item_raddr = (i_cmd.step == pdll_pkg::ST_ITEM_RD) ? NAW'(r_cur) : NAW'(r_c);
        case (i_cmd.step)
            pdll_pkg::ST_W1: begin
                item_we    = 1'b1;
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_waddr = NAW'(r_anode);
                prev_waddr = NAW'(r_anode);
                if (k_back) begin
                    next_wdata = NIL;
                    prev_wdata = link_b ? r_tl : NIL;
                end else if (k_front) begin
                    next_wdata = link_f ? r_hd : NIL;
                    prev_wdata = NIL;
                end else if (k_after) begin
                    next_wdata = r_nx;
                    prev_wdata = r_c;
                end else begin
                    next_wdata = r_c;
                    prev_wdata = r_p;
                end
            end
            pdll_pkg::ST_W2: begin
                next_wdata = r_anode;
                prev_wdata = r_anode;
                if (k_back) begin
                    next_we    = link_b;
                    next_waddr = NAW'(r_tl);
                end else if (k_front) begin
                    prev_we    = link_f;
                    prev_waddr = NAW'(r_hd);
                end else if (k_after) begin
                    next_we    = 1'b1;
                    prev_we    = nxv;
                    prev_waddr = NAW'(r_nx);
                end else begin
                    prev_we    = 1'b1;
                    next_we    = pv;
                    next_waddr = NAW'(r_p);
                end
            end
            pdll_pkg::ST_RM1: begin
                next_we    = pv;
                next_waddr = NAW'(r_p);
                next_wdata = r_nx;
                prev_we    = nxv;
                prev_waddr = NAW'(r_nx);
                prev_wdata = r_p;
            end
            pdll_pkg::ST_TR1: begin
                next_we    = pv;
                next_waddr = NAW'(r_p);
            end
            pdll_pkg::ST_GIVE: begin
                next_we    = 1'b1;
                next_wdata = r_fnt;
            end
            pdll_pkg::ST_CC1: begin
                next_we    = hd2v && hdv && tlv;
                next_waddr = NAW'(r_tl);
                next_wdata = r_hd2;
                prev_we    = hd2v && hdv && tlv;
                prev_waddr = NAW'(r_hd2);
                prev_wdata = r_tl;
            end
            pdll_pkg::ST_FR1: begin
                next_we    = hdv;
                next_waddr = NAW'(r_tl);
                next_wdata = r_fnt;
            end
            default: ;
        endcase
    end

    // working registers and pools
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fnt    <= NIL;
            r_nfresh <= '0;
            r_fht    <= NILH;
            r_hfresh <= '0;
            r_used   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= (i_cmd.step inside {pdll_pkg::ST_FIN, pdll_pkg::ST_NULL,
                                           pdll_pkg::ST_CR_WR});
            if (i_cmd.accept) begin
                r_op   <= pdll_pkg::t_op'(i_req.operation);
                r_h    <= i_req.list_sel;
                r_h2   <= i_req.second_list;
                r_item <= i_req.item_in;
                r_pres <= 1'b0;
            end
            case (i_cmd.step)
                pdll_pkg::ST_DECODE: begin
                    r_hd    <= hr_hd;
                    r_tl    <= hr_tl;
                    r_cur   <= hr_cur;
                    r_mode  <= pdll_pkg::t_mode'(hr_mode);
                    r_cnt   <= hr_cnt;
                    r_fnext <= next_rdata;
                    r_aok   <= (r_fnt != NIL) || (r_nfresh < NIL);
                    r_anode <= (r_fnt != NIL) ? r_fnt : r_nfresh;
                end
                pdll_pkg::ST_EXEC: begin
                    r_c <= (r_op == pdll_pkg::OP_TRIM) ? r_tl : r_cur;
                    if (r_op == pdll_pkg::OP_FIRST) begin
                        r_cur  <= r_hd;
                        r_mode <= hdv ? pdll_pkg::MODE_IN : pdll_pkg::MODE_BEFORE;
                    end else if (r_op == pdll_pkg::OP_LAST) begin
                        r_cur  <= r_tl;
                        r_mode <= tlv ? pdll_pkg::MODE_IN : pdll_pkg::MODE_AFTER;
                    end
                end
                pdll_pkg::ST_LCAP: begin
                    r_nx <= next_rdata;
                    r_p  <= prev_rdata;
                    r_it <= item_rdata;
                end
                pdll_pkg::ST_MOVE: begin
                    if (r_op == pdll_pkg::OP_NEXT) begin
                        if (cur_in && nxv) begin
                            r_cur <= r_nx;
                        end else if (r_mode == pdll_pkg::MODE_BEFORE && hdv) begin
                            r_cur  <= r_hd;
                            r_mode <= pdll_pkg::MODE_IN;
                        end else begin
                            r_cur  <= NIL;
                            r_mode <= pdll_pkg::MODE_AFTER;
                        end
                    end else begin
                        if (cur_in && pv) begin
                            r_cur <= r_p;
                        end else if (r_mode == pdll_pkg::MODE_AFTER && tlv) begin
                            r_cur  <= r_tl;
                            r_mode <= pdll_pkg::MODE_IN;
                        end else begin
                            r_cur  <= NIL;
                            r_mode <= pdll_pkg::MODE_BEFORE;
                        end
                    end
                end
                pdll_pkg::ST_RM1: begin
                    if (!pv) begin
                        r_hd <= r_nx;
                    end
                    if (!nxv) begin
                        r_mode <= pdll_pkg::MODE_AFTER;
                        r_tl   <= r_p;
                    end
                    r_cur <= r_nx;
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - NW'(1);
                    end
                    r_pres <= 1'b1;
                end
                pdll_pkg::ST_TR1: begin
                    if (pv) begin
                        r_tl   <= r_p;
                        r_mode <= pdll_pkg::MODE_IN;
                    end else begin
                        r_mode <= pdll_pkg::MODE_AFTER;
                        r_hd   <= NIL;
                        r_tl   <= NIL;
                    end
                    r_cur  <= r_p;
                    r_cnt  <= r_cnt - NW'(1);
                    r_pres <= 1'b1;
                end
                pdll_pkg::ST_GIVE: r_fnt <= r_c;
                pdll_pkg::ST_W1: begin
                    if (r_fnt != NIL) begin
                        r_fnt <= r_fnext;
                    end else begin
                        r_nfresh <= r_nfresh + NW'(1);
                    end
                end
                pdll_pkg::ST_W2: begin
                    r_cur <= r_anode;
                    r_cnt <= r_cnt + NW'(1);
                    if (k_back) begin
                        if (!link_b) begin
                            r_hd <= r_anode;
                        end
                        r_tl   <= r_anode;
                        r_mode <= pdll_pkg::MODE_IN;
                    end else if (k_front) begin
                        if (!link_f) begin
                            r_tl <= r_anode;
                        end
                        r_hd   <= r_anode;
                        r_mode <= pdll_pkg::MODE_IN;
                    end else if (k_after) begin
                        if (!nxv) begin
                            r_tl <= r_anode;
                        end
                    end else begin
                        if (!pv) begin
                            r_hd <= r_anode;
                        end
                    end
                end
                pdll_pkg::ST_H2CAP: begin
                    r_hd2  <= hr_hd;
                    r_tl2  <= hr_tl;
                    r_cnt2 <= hr_cnt;
                end
                pdll_pkg::ST_CC1: begin
                    if (hd2v) begin
                        if (!(hdv && tlv)) begin
                            r_hd <= r_hd2;
                        end
                        r_tl <= r_tl2;
                    end
                    r_cnt <= r_cnt + r_cnt2;
                end
                pdll_pkg::ST_CC2: begin
                    r_fht              <= HW'(r_h2);
                    r_used[HAW'(r_h2)] <= 1'b0;
                end
                pdll_pkg::ST_FR1: begin
                    if (hdv) begin
                        r_fnt <= r_hd;
                    end
                    r_hd              <= NIL;
                    r_tl              <= NIL;
                    r_cur             <= NIL;
                    r_mode            <= pdll_pkg::MODE_BEFORE;
                    r_cnt             <= '0;
                    r_fht             <= HW'(r_h);
                    r_used[HAW'(r_h)] <= 1'b0;
                end
                pdll_pkg::ST_FIN: begin
                    r_rsp.status           <= (is_ins || r_op == pdll_pkg::OP_APPEND ||
                                               r_op == pdll_pkg::OP_PREPEND) && !r_aok;
                    r_rsp.item_present     <= fin_pres;
                    r_rsp.item_out         <= !fin_pres ? '0 :
                                              (cursor_op ? item_rdata : r_it);
                    r_rsp.new_handle       <= '0;
                    r_rsp.element_count    <= pdll_pkg::COUNT_W'(r_cnt);
                end
                pdll_pkg::ST_NULL: begin
                    r_rsp <= '0;
                end
                pdll_pkg::ST_CR_WR: begin
                    r_rsp.status        <= !cr_ok;
                    r_rsp.item_present  <= 1'b0;
                    r_rsp.item_out      <= '0;
                    r_rsp.new_handle    <= cr_ok ? pdll_pkg::HANDLE_W'(cr_h) : '0;
                    r_rsp.element_count <= '0;
                    if (cr_ok) begin
                        r_used[HAW'(cr_h)] <= 1'b1;
                        if (cr_stack) begin
                            r_fht <= link_rdata;
                        end else begin
                            r_hfresh <= r_hfresh + HW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // memories
    pdll_ram #(.WIDTH(HDW), .DEPTH(NUM_HEADS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    pdll_ram #(.WIDTH(HW), .DEPTH(NUM_HEADS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (HAW'(r_fht)),
        .o_rdata (link_rdata)
    );

    pdll_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (next_raddr),
        .o_rdata (next_rdata)
    );

    pdll_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    pdll_ram #(.WIDTH(IW), .DEPTH(NUM_NODES)) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (item_we),
        .i_waddr (item_waddr),
        .i_wdata (r_item),
        .i_raddr (item_raddr),
        .o_rdata (item_rdata)
    );

    assign o_rsp   = r_rsp;
    assign o_valid = r_valid;

    // a result is only produced by a finishing step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(i_cmd.step) == pdll_pkg::ST_FIN ||
                     $past(i_cmd.step) == pdll_pkg::ST_NULL ||
                     $past(i_cmd.step) == pdll_pkg::ST_CR_WR))
        else $error("result strobe without finishing step");

    // fresh counters never run past the pools
    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfresh <= NIL) && (r_hfresh <= NILH))
        else $error("fresh counter out of range");

    // node allocation only when a node is available
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == pdll_pkg::ST_W1) |-> r_aok)
        else $error("node allocated from an empty pool");

endmodule

// File: rtl/pooled_doubly_linked_list_manager.sv
// top level of the pooled doubly linked list manager
//
// channel   direction  handshake                            payload
// request   in         start, busy (taken: start & !busy)   i_req  (pdll_pkg::t_req)
// result    out        o_valid, one cycle, no stall         o_rsp  (pdll_pkg::t_rsp)
//
// busy stays high after the transfer while the dependent registered reads and
// writes of the head and node memories run, each kind of request on its own path
// through the controller states; inserts, remove and trim take a shorter path
// when no node is free or nothing is removed
// reset clears the free pools to empty stacks with fresh counters, no memory sweep
// the result strobe comes in the first cycle with busy low; the result is held in
// an output register so a new request can be taken in the strobe cycle
module pooled_doubly_linked_list_manager #(
    parameter int NUM_HEADS = 16,
    parameter int NUM_NODES = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pdll_pkg::t_req i_req,
    output pdll_pkg::t_rsp o_rsp,
    output logic           o_valid
);

    pdll_pkg::t_cmd  cmd;
    pdll_pkg::t_stat stat;

    // sequencer
    pdll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (pdll_pkg::t_op'(i_req.operation)),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // storage and datapath
    pdll_dp #(.NUM_HEADS(NUM_HEADS), .NUM_NODES(NUM_NODES)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_stat  (stat),
        .o_rsp   (o_rsp),
        .o_valid (o_valid)
    );

endmodule
